// ----- design/date_time_difference_top_defines.svh -----
// assertion macros for the date and time difference block
`ifndef DATE_TIME_DIFFERENCE_TOP_DEFINES_SVH
`define DATE_TIME_DIFFERENCE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DTD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtd assertion failed");
`define DTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtd assertion failed");
`else
`define DTD_ASSERT_IMPLIES(label, ante, cons)
`define DTD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/dtd_pkg.sv -----
package dtd_pkg;

    localparam int YEAR_MAX      = 9999;
    localparam int MONTH_MAX     = 12;
    localparam int HOUR_MAX      = 23;
    localparam int MINUTE_MAX    = 59;
    localparam int SECOND_MAX    = 59;
    localparam int DAYS_PER_YEAR = 365;
    localparam int EPOCH_YEARS   = 400;
    localparam int LEAP_FEB_DAYS = 29;
    localparam int MONTH_FEB     = 2;
    localparam int MINUTES_RADIX = 60;
    localparam int HOURS_RADIX   = 24;
    localparam int DIV_25        = 25;
    // 2^16 / 25 rounded up, exact for dividends below 4681
    localparam logic [11:0] RECIP_25 = 12'd2622;

    typedef struct packed {
        logic [5:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  hour_a;
        logic [5:0]  minute_a;
        logic [5:0]  second_a;
        logic [5:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
        logic [4:0]  hour_b;
        logic [5:0]  minute_b;
        logic [5:0]  second_b;
    } dtd_req_t;

    typedef struct packed {
        logic        valid_res;
        logic [21:0] day_count;
        logic [4:0]  diff_hours;
        logic [5:0]  diff_minutes;
        logic [5:0]  diff_seconds;
    } dtd_rsp_t;

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } dtd_date_t;

    typedef struct packed {
        logic        ok;
        logic [21:0] day_num;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } dtd_stamp_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } dtd_adv_t;

    function automatic logic [5:0] month_len(input logic [3:0] m);
        logic [5:0] len;
        begin
            case (m)
                4'd1:    len = 6'd31;
                4'd2:    len = 6'd28;
                4'd3:    len = 6'd31;
                4'd4:    len = 6'd30;
                4'd5:    len = 6'd31;
                4'd6:    len = 6'd30;
                4'd7:    len = 6'd31;
                4'd8:    len = 6'd31;
                4'd9:    len = 6'd30;
                4'd10:   len = 6'd31;
                4'd11:   len = 6'd30;
                4'd12:   len = 6'd31;
                default: len = 6'd0;
            endcase
            return len;
        end
    endfunction

    // days before the month in a year starting in march
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] off;
        begin
            case (m)
                4'd1:    off = 9'd306;
                4'd2:    off = 9'd337;
                4'd3:    off = 9'd0;
                4'd4:    off = 9'd31;
                4'd5:    off = 9'd61;
                4'd6:    off = 9'd92;
                4'd7:    off = 9'd122;
                4'd8:    off = 9'd153;
                4'd9:    off = 9'd184;
                4'd10:   off = 9'd214;
                4'd11:   off = 9'd245;
                4'd12:   off = 9'd275;
                default: off = 9'd0;
            endcase
            return off;
        end
    endfunction

endpackage

// ----- design/date_time_difference_top.sv -----
// channel   direction  payload               handshake
// req       in         dtd_pkg::dtd_req_t    req_valid, req_stall
// rsp       out        dtd_pkg::dtd_rsp_t    rsp_valid, rsp_stall
//
// six register stages, one transaction per cycle sustained while rsp_stall is low
// stages 1-3 per stamp: reciprocal multiplies, checks and partial sums, day number
// stages 4-6: ordering compare, seconds and minutes borrow, hours and days
// rst_n clears the stage valid bits only
// each stage loads when empty or when the stage after it moves, so bubbles fill
// req_stall is high only when all six stages hold data and rsp_stall is high
`include "date_time_difference_top_defines.svh"

module date_time_difference_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dtd_pkg::dtd_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dtd_pkg::dtd_rsp_t rsp_data
);

    logic [6:1] v_reg;
    logic [6:1] v_next;
    logic [7:1] en;

    dtd_pkg::dtd_adv_t   adv;
    dtd_pkg::dtd_date_t  date_a;
    dtd_pkg::dtd_date_t  date_b;
    dtd_pkg::dtd_stamp_t stamp_a;
    dtd_pkg::dtd_stamp_t stamp_b;

    // stage 4
    logic                ok4_reg;
    dtd_pkg::dtd_stamp_t big_reg;
    dtd_pkg::dtd_stamp_t small_reg;
    logic                a_first;

    // stage 5
    logic        ok5_reg;
    logic [5:0]  sec5_reg;
    logic [5:0]  min5_reg;
    logic        bm5_reg;
    logic [4:0]  hbig5_reg;
    logic [4:0]  hsmall5_reg;
    logic [21:0] dnbig5_reg;
    logic [21:0] dnsmall5_reg;
    logic [6:0]  sd;
    logic [6:0]  md;
    logic [5:0]  sec5_next;
    logic [5:0]  min5_next;

    // stage 6
    dtd_pkg::dtd_rsp_t rsp_reg;
    dtd_pkg::dtd_rsp_t rsp_next;
    logic [5:0]        hd;

    always_comb
    begin
        en[7] = !rsp_stall;
        for (int i = 6; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i + 1];
        end
        v_next[1] = en[1] ? req_valid : v_reg[1];
        for (int i = 2; i <= 6; i++)
        begin
            v_next[i] = en[i] ? v_reg[i - 1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign req_stall = !en[1];
    assign adv.s1    = en[1];
    assign adv.s2    = en[2];
    assign adv.s3    = en[3];

    always_comb
    begin
        date_a.day    = req_data.day_a;
        date_a.month  = req_data.month_a;
        date_a.year   = req_data.year_a;
        date_a.hour   = req_data.hour_a;
        date_a.minute = req_data.minute_a;
        date_a.second = req_data.second_a;
        date_b.day    = req_data.day_b;
        date_b.month  = req_data.month_b;
        date_b.year   = req_data.year_b;
        date_b.hour   = req_data.hour_b;
        date_b.minute = req_data.minute_b;
        date_b.second = req_data.second_b;
    end

    dtd_stamp u_stamp_a (
        .clk   (clk),
        .adv   (adv),
        .date  (date_a),
        .stamp (stamp_a)
    );

    dtd_stamp u_stamp_b (
        .clk   (clk),
        .adv   (adv),
        .date  (date_b),
        .stamp (stamp_b)
    );

    assign a_first = {stamp_a.day_num, stamp_a.hour, stamp_a.minute, stamp_a.second}
                     >= {stamp_b.day_num, stamp_b.hour, stamp_b.minute, stamp_b.second};

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ok4_reg   <= stamp_a.ok && stamp_b.ok;
            big_reg   <= a_first ? stamp_a : stamp_b;
            small_reg <= a_first ? stamp_b : stamp_a;
        end
    end

    always_comb
    begin
        sd        = {1'b0, big_reg.second} - {1'b0, small_reg.second};
        sec5_next = sd[6] ? (sd[5:0] + 6'(dtd_pkg::MINUTES_RADIX)) : sd[5:0];
        md        = {1'b0, big_reg.minute} - {1'b0, small_reg.minute} - 7'(sd[6]);
        min5_next = md[6] ? (md[5:0] + 6'(dtd_pkg::MINUTES_RADIX)) : md[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            ok5_reg      <= ok4_reg;
            sec5_reg     <= sec5_next;
            min5_reg     <= min5_next;
            bm5_reg      <= md[6];
            hbig5_reg    <= big_reg.hour;
            hsmall5_reg  <= small_reg.hour;
            dnbig5_reg   <= big_reg.day_num;
            dnsmall5_reg <= small_reg.day_num;
        end
    end

    always_comb
    begin
        hd = {1'b0, hbig5_reg} - {1'b0, hsmall5_reg} - 6'(bm5_reg);
        rsp_next.valid_res    = ok5_reg;
        rsp_next.day_count    = '0;
        rsp_next.diff_hours   = '0;
        rsp_next.diff_minutes = '0;
        rsp_next.diff_seconds = '0;
        if (ok5_reg)
        begin
            rsp_next.day_count    = dnbig5_reg - dnsmall5_reg - 22'(hd[5]);
            rsp_next.diff_hours   = hd[5] ? (hd[4:0] + 5'(dtd_pkg::HOURS_RADIX)) : hd[4:0];
            rsp_next.diff_minutes = min5_reg;
            rsp_next.diff_seconds = sec5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = v_reg[6];
    assign rsp_data  = rsp_reg;

    `DTD_ASSERT_IMPLIES(a_stall_only_when_full, req_stall, (&v_reg) && rsp_stall)
    `DTD_ASSERT_IMPLIES(a_invalid_gives_zero, rsp_valid && !rsp_data.valid_res, (rsp_data.day_count == 22'd0) && (rsp_data.diff_hours == 5'd0) && (rsp_data.diff_minutes == 6'd0) && (rsp_data.diff_seconds == 6'd0))
    `DTD_ASSERT_IMPLIES(a_time_in_range, rsp_valid && rsp_data.valid_res, (rsp_data.diff_hours <= 5'(dtd_pkg::HOUR_MAX)) && (rsp_data.diff_minutes <= 6'(dtd_pkg::MINUTE_MAX)) && (rsp_data.diff_seconds <= 6'(dtd_pkg::SECOND_MAX)))
    `DTD_ASSERT_IMPLIES(a_ordered, v_reg[4] && ok4_reg, {big_reg.day_num, big_reg.hour, big_reg.minute, big_reg.second} >= {small_reg.day_num, small_reg.hour, small_reg.minute, small_reg.second})
    `DTD_ASSERT_NEXT(a_out_moves, rsp_valid && !rsp_stall && !v_reg[5], !rsp_valid)

endmodule

// ----- design/dtd_stamp.sv -----
module dtd_stamp (
    input  logic                clk,
    input  dtd_pkg::dtd_adv_t   adv,
    input  dtd_pkg::dtd_date_t  date,
    output dtd_pkg::dtd_stamp_t stamp
);

    // stage 1
    dtd_pkg::dtd_date_t date_reg;
    logic [14:0]        yy_reg;
    logic [23:0]        py_reg;
    logic [24:0]        pyy_reg;
    logic [14:0]        yy_next;
    logic [23:0]        py_next;
    logic [24:0]        pyy_next;

    // stage 2
    logic        ok_reg;
    logic [21:0] a_reg;
    logic [9:0]  b_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic        ok_next;
    logic [21:0] a_next;
    logic [9:0]  b_next;
    logic [7:0]  q_y;
    logic        div100_y;
    logic        leap;
    logic [5:0]  len;
    logic [8:0]  q100;

    // stage 3
    dtd_pkg::dtd_stamp_t stamp_reg;
    dtd_pkg::dtd_stamp_t stamp_next;

    always_comb
    begin
        yy_next = {1'b0, date.year} + 15'(dtd_pkg::EPOCH_YEARS)
                  - ((date.month <= 4'(dtd_pkg::MONTH_FEB)) ? 15'd1 : 15'd0);
        py_next  = 24'(date.year[13:2]) * 24'(dtd_pkg::RECIP_25);
        pyy_next = 25'(yy_next[14:2]) * 25'(dtd_pkg::RECIP_25);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            date_reg <= date;
            yy_reg   <= yy_next;
            py_reg   <= py_next;
            pyy_reg  <= pyy_next;
        end
    end

    always_comb
    begin
        q_y      = py_reg[23:16];
        div100_y = (12'(q_y) * 12'(dtd_pkg::DIV_25)) == date_reg.year[13:2];
        leap     = (date_reg.year[1:0] == 2'd0) && (!div100_y || (q_y[1:0] == 2'd0));
        len      = (date_reg.month == 4'(dtd_pkg::MONTH_FEB) && leap)
                   ? 6'(dtd_pkg::LEAP_FEB_DAYS) : dtd_pkg::month_len(date_reg.month);
        ok_next  = (date_reg.year <= 14'(dtd_pkg::YEAR_MAX))
                   && (date_reg.month != 4'd0)
                   && (date_reg.month <= 4'(dtd_pkg::MONTH_MAX))
                   && (date_reg.day != 6'd0)
                   && (date_reg.day <= len)
                   && (date_reg.hour <= 5'(dtd_pkg::HOUR_MAX))
                   && (date_reg.minute <= 6'(dtd_pkg::MINUTE_MAX))
                   && (date_reg.second <= 6'(dtd_pkg::SECOND_MAX));
        q100     = pyy_reg[24:16];
        a_next   = 22'(yy_reg) * 22'(dtd_pkg::DAYS_PER_YEAR) + 22'(yy_reg[14:2])
                   - 22'(q100) + 22'(q100[8:2]);
        b_next   = 10'(dtd_pkg::month_offset(date_reg.month)) + 10'(date_reg.day);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            ok_reg     <= ok_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            hour_reg   <= date_reg.hour;
            minute_reg <= date_reg.minute;
            second_reg <= date_reg.second;
        end
    end

    always_comb
    begin
        stamp_next.ok      = ok_reg;
        stamp_next.day_num = a_reg + 22'(b_reg) - 22'd1;
        stamp_next.hour    = hour_reg;
        stamp_next.minute  = minute_reg;
        stamp_next.second  = second_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            stamp_reg <= stamp_next;
        end
    end

    assign stamp = stamp_reg;

endmodule

// ----- tb/sv/dtd_diff_checker.sv -----
`timescale 1ns / 1ps

module dtd_diff_checker
    import dtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  dtd_req_t req_data,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  dtd_rsp_t rsp_data,
    output int       err_count,
    output int       pending_count,
    output int       result_count,
    output int       legal_count
);

    localparam longint SECS_PER_MINUTE = MINUTES_RADIX;
    localparam longint SECS_PER_HOUR   = MINUTES_RADIX * MINUTES_RADIX;
    localparam longint SECS_PER_DAY    = HOURS_RADIX * SECS_PER_HOUR;

    dtd_rsp_t expected_diffs[$];
    int       mismatches   = 0;
    int       results_seen = 0;
    int       legal_seen   = 0;

    assign err_count    = mismatches;
    assign result_count = results_seen;
    assign legal_count  = legal_seen;

    function automatic dtd_date_t first_stamp(input dtd_req_t t);
        dtd_date_t s;
        s.day    = t.day_a;
        s.month  = t.month_a;
        s.year   = t.year_a;
        s.hour   = t.hour_a;
        s.minute = t.minute_a;
        s.second = t.second_a;
        return s;
    endfunction

    function automatic dtd_date_t second_stamp(input dtd_req_t t);
        dtd_date_t s;
        s.day    = t.day_b;
        s.month  = t.month_b;
        s.year   = t.year_b;
        s.hour   = t.hour_b;
        s.minute = t.minute_b;
        s.second = t.second_b;
        return s;
    endfunction

    function automatic bit stamp_is_legal(input dtd_date_t s);
        int  last_day;
        bit  leap;
        int  y;
        y = int'(s.year);
        if (y > YEAR_MAX || s.month < 1 || s.month > MONTH_MAX || s.day < 1)
        begin
            return 1'b0;
        end
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        if (s.month == MONTH_FEB)
        begin
            last_day = leap ? LEAP_FEB_DAYS : LEAP_FEB_DAYS - 1;
        end
        else if (s.month == 4 || s.month == 6 || s.month == 9 || s.month == 11)
        begin
            last_day = 30;
        end
        else
        begin
            last_day = 31;
        end
        if (s.day > last_day)
        begin
            return 1'b0;
        end
        return (s.hour <= HOUR_MAX) && (s.minute <= MINUTE_MAX) && (s.second <= SECOND_MAX);
    endfunction

    // march-based year so the leap day falls at the end
    function automatic longint stamp_to_seconds(input dtd_date_t s);
        longint y;
        longint m;
        longint days;
        y = longint'(s.year) + EPOCH_YEARS;
        if (s.month <= MONTH_FEB)
        begin
            y = y - 1;
            m = longint'(s.month) + 9;
        end
        else
        begin
            m = longint'(s.month) - 3;
        end
        days = DAYS_PER_YEAR * y + y / 4 - y / 100 + y / 400 + (153 * m + 2) / 5
            + longint'(s.day) - 1;
        return days * SECS_PER_DAY + longint'(s.hour) * SECS_PER_HOUR
            + longint'(s.minute) * SECS_PER_MINUTE + longint'(s.second);
    endfunction

    function automatic dtd_rsp_t predict_difference(input dtd_req_t t);
        dtd_rsp_t  r;
        dtd_date_t a;
        dtd_date_t b;
        longint    ta;
        longint    tb;
        longint    gap;
        longint    rem;
        r = '0;
        a = first_stamp(t);
        b = second_stamp(t);
        if (stamp_is_legal(a) && stamp_is_legal(b))
        begin
            ta  = stamp_to_seconds(a);
            tb  = stamp_to_seconds(b);
            gap = (ta >= tb) ? ta - tb : tb - ta;
            rem = gap % SECS_PER_DAY;
            r.valid_res    = 1'b1;
            r.day_count    = 22'(gap / SECS_PER_DAY);
            r.diff_hours   = 5'(rem / SECS_PER_HOUR);
            r.diff_minutes = 6'((rem % SECS_PER_HOUR) / SECS_PER_MINUTE);
            r.diff_seconds = 6'(rem % SECS_PER_MINUTE);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch
        dtd_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_diffs.push_back(predict_difference(req_data));
            end
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (expected_diffs.size() == 0)
                begin
                    report_mismatch("result with no transaction waiting");
                end
                else
                begin
                    want = expected_diffs.pop_front();
                    if (want.valid_res)
                    begin
                        legal_seen++;
                    end
                    if (rsp_data.valid_res !== want.valid_res)
                    begin
                        report_mismatch($sformatf("valid_res got %0b want %0b",
                            rsp_data.valid_res, want.valid_res));
                    end
                    if (rsp_data.day_count !== want.day_count)
                    begin
                        report_mismatch($sformatf("day_count got %0d want %0d",
                            rsp_data.day_count, want.day_count));
                    end
                    if (rsp_data.diff_hours !== want.diff_hours)
                    begin
                        report_mismatch($sformatf("diff_hours got %0d want %0d",
                            rsp_data.diff_hours, want.diff_hours));
                    end
                    if (rsp_data.diff_minutes !== want.diff_minutes)
                    begin
                        report_mismatch($sformatf("diff_minutes got %0d want %0d",
                            rsp_data.diff_minutes, want.diff_minutes));
                    end
                    if (rsp_data.diff_seconds !== want.diff_seconds)
                    begin
                        report_mismatch($sformatf("diff_seconds got %0d want %0d",
                            rsp_data.diff_seconds, want.diff_seconds));
                    end
                end
            end
        end
        pending_count <= expected_diffs.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import dtd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int MAX_WAIT     = 13;
    localparam int SETTLE       = 20;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    dtd_req_t req_data;
    logic     rsp_valid;
    logic     rsp_stall;
    dtd_rsp_t rsp_data;

    int err_count;
    int pending_count;
    int result_count;
    int legal_count;
    int sent_count  = 0;
    int cycle_count = 0;
    bit send_quiet  = 1'b0;
    bit recv_quiet  = 1'b0;

    date_time_difference_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    dtd_diff_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .err_count     (err_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .legal_count   (legal_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, pending_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic dtd_date_t stamp(input int d, input int m, input int y,
                                        input int h, input int mi, input int s);
        dtd_date_t r;
        r.day    = 6'(d);
        r.month  = 4'(m);
        r.year   = 14'(y);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
        return r;
    endfunction

    function automatic dtd_req_t pair_of(input dtd_date_t a, input dtd_date_t b);
        dtd_req_t t;
        t.day_a    = a.day;
        t.month_a  = a.month;
        t.year_a   = a.year;
        t.hour_a   = a.hour;
        t.minute_a = a.minute;
        t.second_a = a.second;
        t.day_b    = b.day;
        t.month_b  = b.month;
        t.year_b   = b.year;
        t.hour_b   = b.hour;
        t.minute_b = b.minute;
        t.second_b = b.second;
        return t;
    endfunction

    function automatic dtd_date_t legal_stamp();
        int y;
        int d;
        case ($urandom_range(0, 7))
            0:       y = $urandom_range(0, YEAR_MAX / 100) * 100;
            1:       y = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                              : YEAR_MAX - $urandom_range(0, 3);
            default: y = $urandom_range(0, YEAR_MAX);
        endcase
        // late days are sometimes past the end of a short month
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(LEAP_FEB_DAYS, 31)
                                        : $urandom_range(1, LEAP_FEB_DAYS - 1);
        return stamp(d, $urandom_range(1, MONTH_MAX), y, $urandom_range(0, HOUR_MAX),
                     $urandom_range(0, MINUTE_MAX), $urandom_range(0, SECOND_MAX));
    endfunction

    function automatic dtd_date_t broken_stamp(input dtd_date_t s);
        dtd_date_t r;
        r = s;
        case ($urandom_range(0, 5))
            0:       r.day    = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(32, 63));
            1:       r.month  = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(MONTH_MAX + 1, 15));
            2:       r.year   = 14'($urandom_range(YEAR_MAX + 1, 16383));
            3:       r.hour   = 5'($urandom_range(HOUR_MAX + 1, 31));
            4:       r.minute = 6'($urandom_range(MINUTE_MAX + 1, 63));
            default: r.second = 6'($urandom_range(SECOND_MAX + 1, 63));
        endcase
        return r;
    endfunction

    function automatic dtd_req_t random_pair();
        dtd_date_t   a;
        dtd_date_t   b;
        logic [95:0] raw;
        int          sel;
        sel = $urandom_range(0, 99);
        a   = legal_stamp();
        b   = legal_stamp();
        if (sel < 20)
        begin
            b        = a;
            b.hour   = 5'($urandom_range(0, HOUR_MAX));
            b.minute = 6'($urandom_range(0, MINUTE_MAX));
            b.second = 6'($urandom_range(0, SECOND_MAX));
            if ($urandom_range(0, 1))
            begin
                b.day = 6'($urandom_range(1, LEAP_FEB_DAYS - 1));
            end
        end
        else if (sel >= 72 && sel < 85)
        begin
            if ($urandom_range(0, 1))
            begin
                a = broken_stamp(a);
            end
            else
            begin
                b = broken_stamp(b);
            end
        end
        if (sel >= 85)
        begin
            raw = {$urandom, $urandom, $urandom};
            return raw[$bits(dtd_req_t)-1:0];
        end
        return pair_of(a, b);
    endfunction

    task automatic send_pair(input dtd_req_t item);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do @(posedge clk); while (req_stall !== 1'b0);
        sent_count++;
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    initial
    begin : receiver
        int stall_len;
        rsp_stall = 1'b0;
        forever
        begin
            if ($urandom_range(0, 63) == 0)
            begin
                recv_quiet = !recv_quiet;
            end
            stall_len = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
        end
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners and every reason a stamp can be rejected
        send_pair('0);
        send_pair('1);
        send_pair(pair_of(stamp(1, 1, 0, 0, 0, 0), stamp(31, 12, YEAR_MAX, 23, 59, 59)));
        send_pair(pair_of(stamp(31, 12, YEAR_MAX, 23, 59, 59), stamp(1, 1, 0, 0, 0, 0)));
        send_pair(pair_of(stamp(29, 2, 2024, 12, 30, 45), stamp(29, 2, 2024, 12, 30, 45)));
        send_pair(pair_of(stamp(29, 2, 2000, 6, 0, 1), stamp(28, 2, 1900, 18, 59, 0)));
        send_pair(pair_of(stamp(29, 2, 1900, 0, 0, 0), stamp(1, 3, 1900, 0, 0, 0)));
        send_pair(pair_of(stamp(29, 2, 2023, 0, 0, 0), stamp(1, 3, 2023, 0, 0, 0)));
        send_pair(pair_of(stamp(30, 2, 2024, 0, 0, 0), stamp(1, 3, 2024, 0, 0, 0)));
        send_pair(pair_of(stamp(31, 4, 2021, 0, 0, 0), stamp(1, 5, 2021, 0, 0, 0)));
        send_pair(pair_of(stamp(32, 1, 2021, 0, 0, 0), stamp(1, 2, 2021, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 13, 2021, 0, 0, 0), stamp(1, 12, 2021, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 1, 10000, 0, 0, 0), stamp(1, 1, 9999, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 1, 2021, 24, 0, 0), stamp(1, 1, 2021, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 1, 2021, 0, 60, 0), stamp(1, 1, 2021, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 1, 2021, 0, 0, 60), stamp(1, 1, 2021, 0, 0, 0)));
        send_pair(pair_of(stamp(31, 12, 2023, 23, 59, 59), stamp(1, 1, 2024, 0, 0, 0)));
        send_pair(pair_of(stamp(29, 2, 0, 1, 2, 3), stamp(1, 3, 0, 3, 2, 1)));
        send_pair(pair_of(stamp(28, 2, 2100, 0, 0, 0), stamp(1, 3, 2100, 0, 0, 0)));
        send_pair(pair_of(stamp(15, 6, 2000, 0, 0, 0), stamp(0, 6, 2000, 0, 0, 0)));
        send_pair(pair_of(stamp(15, 6, 2000, 0, 0, 0), stamp(15, 6, 2000, 31, 63, 63)));
        send_pair(pair_of(stamp(31, 12, YEAR_MAX, 23, 59, 59),
                          stamp(31, 12, YEAR_MAX, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 1, 2000, 0, 0, 0), stamp(63, 15, 16383, 0, 0, 0)));
        send_pair(pair_of(stamp(1, 0, 2000, 0, 0, 0), stamp(1, 1, 2000, 0, 0, 0)));
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                send_quiet = ($urandom_range(0, 2) == 0);
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_for_results();
            end
            send_pair(random_pair());
        end
        wait_for_results();
        repeat (SETTLE) @(posedge clk);

        $display("summary: %0d timestamp pairs sent, %0d differences checked, %0d on two legal stamps",
            sent_count, result_count, legal_count);
        if (err_count == 0 && pending_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
